>>> hw/rtl/sll_pkg.sv
// ----------------------------------------------------------------------------
// sll_pkg
// Shared types, token and error codes, and character helpers for the
// small language lexer.
// ----------------------------------------------------------------------------
package sll_pkg;

  localparam int unsigned LENGTH_BITS_DEF = 16;
  localparam int unsigned OFFSET_BITS_DEF = 32;
  localparam int unsigned LINE_BITS       = 24;
  localparam logic [LINE_BITS-1:0] START_LINE_RESET = 24'd1;

  typedef enum logic [3:0] {
    MODE_IDLE    = 4'd0,
    MODE_IDENT   = 4'd1,
    MODE_NUMBER  = 4'd2,
    MODE_AFTER_N = 4'd3,
    MODE_KEYWORD = 4'd4,
    MODE_STRING  = 4'd5,
    MODE_LT      = 4'd6,
    MODE_GT      = 4'd7,
    MODE_EQ      = 4'd8,
    MODE_BANG    = 4'd9
  } scan_mode_e;

  // Token kinds.
  localparam logic [4:0] KIND_IDENT   = 5'd0;
  localparam logic [4:0] KIND_NUMBER  = 5'd1;
  localparam logic [4:0] KIND_SQ      = 5'd2;
  localparam logic [4:0] KIND_DQ      = 5'd3;
  localparam logic [4:0] KIND_KW_BASE = 5'd4;
  localparam logic [4:0] KIND_PLUS    = 5'd10;
  localparam logic [4:0] KIND_MINUS   = 5'd11;
  localparam logic [4:0] KIND_STAR    = 5'd12;
  localparam logic [4:0] KIND_SLASH   = 5'd13;
  localparam logic [4:0] KIND_LPAREN  = 5'd14;
  localparam logic [4:0] KIND_RPAREN  = 5'd15;
  localparam logic [4:0] KIND_DOT     = 5'd16;
  localparam logic [4:0] KIND_LT      = 5'd17;
  localparam logic [4:0] KIND_GT      = 5'd19;
  localparam logic [4:0] KIND_ASSIGN  = 5'd21;
  localparam logic [4:0] KIND_NE      = 5'd23;
  localparam logic [4:0] KIND_EOF     = 5'd24;
  localparam logic [4:0] KIND_ERROR   = 5'd25;

  // Error kinds.
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_NL_IN_STR  = 3'd1;
  localparam logic [2:0] ERR_END_IN_STR = 3'd2;
  localparam logic [2:0] ERR_BAD_ESCAPE = 3'd3;
  localparam logic [2:0] ERR_LONE_BANG  = 3'd4;
  localparam logic [2:0] ERR_UNEXPECTED = 3'd5;

  // Keyword ids.
  localparam logic [2:0] KW_AND   = 3'd0;
  localparam logic [2:0] KW_OR    = 3'd1;
  localparam logic [2:0] KW_NOT   = 3'd2;
  localparam logic [2:0] KW_NIL   = 3'd3;
  localparam logic [2:0] KW_TRUE  = 3'd4;
  localparam logic [2:0] KW_FALSE = 3'd5;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_BSL = 8'h5C;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_letter(c) || is_digit(c);
  endfunction

  // Count of characters after the first letter, or after no/ni, of each keyword.
  function automatic logic [2:0] kw_len(input logic [2:0] id);
    logic [2:0] len;
    case (id)
      KW_AND:   len = 3'd2;
      KW_OR:    len = 3'd1;
      KW_NOT:   len = 3'd1;
      KW_NIL:   len = 3'd1;
      KW_TRUE:  len = 3'd3;
      KW_FALSE: len = 3'd4;
      default:  len = 3'd2;
    endcase
    return len;
  endfunction

  // Expected character at position idx after the first letter, or after no/ni.
  function automatic logic [7:0] kw_char(input logic [2:0] id, input logic [1:0] idx);
    logic [7:0] c;
    case (id)
      KW_OR:    c = "r";
      KW_NOT:   c = "t";
      KW_NIL:   c = "l";
      KW_TRUE: begin
        case (idx)
          2'd0:    c = "r";
          2'd1:    c = "u";
          default: c = "e";
        endcase
      end
      KW_FALSE: begin
        case (idx)
          2'd0:    c = "a";
          2'd1:    c = "l";
          2'd2:    c = "s";
          default: c = "e";
        endcase
      end
      default: c = (idx == 2'd0) ? "n" : "d";
    endcase
    return c;
  endfunction

endpackage

>>> hw/rtl/small_language_lexer.sv
// Each accepted byte writes its results into a four-entry result queue. Throughput: one
// byte per cycle; a byte that ends one token and is itself a one-byte token or an error
//   gives two results, which leave the queue one per cycle unless the output stalls.
// The input stalls while the queue holds more than two results.
// Reset clears the scanner to idle, offset and token state to zero, the line counter to 1,
//   and empties the result queue.
// ----------------------------------------------------------------------------
// small_language_lexer
// Byte-at-a-time lexical scanner: one source byte in, up to two tokens out.
// ----------------------------------------------------------------------------
module small_language_lexer #(
  parameter int unsigned LENGTH_BITS = sll_pkg::LENGTH_BITS_DEF,
  parameter int unsigned OFFSET_BITS = sll_pkg::OFFSET_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sll_pkg::LINE_BITS-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  ch_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [4:0]                  token_kind_o,
  output logic [2:0]                  error_kind_o,
  output logic [OFFSET_BITS-1:0]      start_offset_o,
  output logic [LENGTH_BITS-1:0]      token_length_o,
  output logic [sll_pkg::LINE_BITS-1:0] line_number_o,
  output logic                        last_o
);
  import sll_pkg::*;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned PTR_W  = $clog2(QDEPTH);
  localparam int unsigned CNT_W  = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [4:0]             kind;
    logic [2:0]             err;
    logic [OFFSET_BITS-1:0] start;
    logic [LENGTH_BITS-1:0] len;
    logic [LINE_BITS-1:0]   line;
    logic                   last;
  } res_t;

  // Scanner state.
  scan_mode_e             mode_q, mode_d;
  logic [2:0]             kw_id_q, kw_id_d;
  logic [2:0]             kw_match_q, kw_match_d;
  logic                   dq_q, dq_d;
  logic                   esc_q, esc_d;
  logic [OFFSET_BITS-1:0] tok_start_q, tok_start_d;
  logic [LENGTH_BITS-1:0] tok_len_q, tok_len_d;
  logic [OFFSET_BITS-1:0] offset_q;
  logic [LINE_BITS-1:0]   line_q, line_d;

  // Result queue.
  res_t                   queue_q [QDEPTH];
  logic [PTR_W-1:0]       wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]       count_q;

  logic                   accept, pop;
  logic [LENGTH_BITS-1:0] len_inc;
  logic [2:0]             kw_id_eff;
  logic                   run_idle;
  logic                   e1_v, e2_v;
  res_t                   e1, e2;
  res_t                   push_a, push_b;

  assign in_stall_o  = (count_q > CNT_W'(QDEPTH - 2));
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && !out_stall_i;

  assign len_inc   = (&tok_len_q) ? tok_len_q : tok_len_q + LENGTH_BITS'(1);
  assign kw_id_eff = (kw_id_q < 3'd6) ? kw_id_q : KW_AND;

  always_comb begin
    mode_d      = mode_q;
    kw_id_d     = kw_id_q;
    kw_match_d  = kw_match_q;
    dq_d        = dq_q;
    esc_d       = esc_q;
    tok_start_d = tok_start_q;
    tok_len_d   = tok_len_q;
    line_d      = line_q;
    run_idle    = 1'b0;
    e1_v        = 1'b0;
    e2_v        = 1'b0;
    e1          = '{kind: KIND_IDENT, err: ERR_NONE, start: tok_start_q, len: tok_len_q,
                    line: line_q, last: 1'b0};
    e2          = '{kind: KIND_ERROR, err: ERR_NONE, start: offset_q,
                    len: LENGTH_BITS'(1), line: line_q, last: 1'b1};

    // First look at the byte in the mode left by the previous byte.
    case (mode_q)
      MODE_IDENT, MODE_AFTER_N: begin
        if (mode_q == MODE_AFTER_N && ch_i == "i") begin
          tok_len_d  = len_inc;
          mode_d     = MODE_KEYWORD;
          kw_id_d    = KW_NIL;
          kw_match_d = 3'd0;
        end else if (mode_q == MODE_AFTER_N && ch_i == "o") begin
          tok_len_d  = len_inc;
          mode_d     = MODE_KEYWORD;
          kw_id_d    = KW_NOT;
          kw_match_d = 3'd0;
        end else if (is_alnum(ch_i)) begin
          tok_len_d = len_inc;
          mode_d    = MODE_IDENT;
        end else begin
          e1_v     = 1'b1;
          run_idle = 1'b1;
        end
      end
      MODE_NUMBER: begin
        if (is_digit(ch_i)) begin
          tok_len_d = len_inc;
        end else begin
          e1_v      = 1'b1;
          e1.kind   = KIND_NUMBER;
          run_idle  = 1'b1;
        end
      end
      MODE_KEYWORD: begin
        if (kw_match_q < kw_len(kw_id_eff) &&
            ch_i == kw_char(kw_id_eff, kw_match_q[1:0])) begin
          kw_match_d = kw_match_q + 3'd1;
          tok_len_d  = len_inc;
        end else if (is_alnum(ch_i)) begin
          tok_len_d = len_inc;
          mode_d    = MODE_IDENT;
        end else begin
          e1_v = 1'b1;
          if (kw_match_q == kw_len(kw_id_eff)) begin
            e1.kind = KIND_KW_BASE + {2'b00, kw_id_eff};
          end
          run_idle = 1'b1;
        end
      end
      MODE_STRING: begin
        if (esc_q) begin
          esc_d = 1'b0;
          if (ch_i == "'" || ch_i == "\"" || ch_i == CH_BSL || ch_i == "n" ||
              ch_i == "r" || ch_i == "t") begin
            tok_len_d = len_inc;
          end else begin
            e1_v     = 1'b1;
            e1.kind  = KIND_ERROR;
            e1.err   = ERR_BAD_ESCAPE;
            e1.len   = '0;
            run_idle = 1'b1;
          end
        end else if (ch_i == CH_LF || ch_i == CH_NUL) begin
          e1_v     = 1'b1;
          e1.kind  = KIND_ERROR;
          e1.err   = (ch_i == CH_LF) ? ERR_NL_IN_STR : ERR_END_IN_STR;
          e1.len   = '0;
          run_idle = 1'b1;
        end else if (ch_i == CH_BSL) begin
          esc_d     = 1'b1;
          tok_len_d = len_inc;
        end else if (ch_i == (dq_q ? 8'("\"") : 8'("'"))) begin
          // Closing quote belongs to the string and is consumed here.
          tok_len_d = len_inc;
          e1_v      = 1'b1;
          e1.kind   = dq_q ? KIND_DQ : KIND_SQ;
          e1.len    = len_inc;
          e1.last   = 1'b1;
          mode_d    = MODE_IDLE;
        end else begin
          tok_len_d = len_inc;
        end
      end
      MODE_LT, MODE_GT, MODE_EQ: begin
        e1_v    = 1'b1;
        e1.kind = (mode_q == MODE_LT) ? KIND_LT : (mode_q == MODE_GT) ? KIND_GT : KIND_ASSIGN;
        if (ch_i == "=") begin
          e1.kind = e1.kind + 5'd1;
          e1.len  = LENGTH_BITS'(2);
          e1.last = 1'b1;
          mode_d  = MODE_IDLE;
        end else begin
          e1.len   = LENGTH_BITS'(1);
          run_idle = 1'b1;
        end
      end
      MODE_BANG: begin
        e1_v = 1'b1;
        if (ch_i == "=") begin
          e1.kind = KIND_NE;
          e1.len  = LENGTH_BITS'(2);
          e1.last = 1'b1;
          mode_d  = MODE_IDLE;
        end else begin
          e1.kind  = KIND_ERROR;
          e1.err   = ERR_LONE_BANG;
          e1.len   = '0;
          run_idle = 1'b1;
        end
      end
      default: begin
        run_idle = 1'b1;
      end
    endcase

    // Idle: the byte starts a new token (or is re-examined after ending one).
    if (run_idle) begin
      tok_start_d = offset_q;
      tok_len_d   = LENGTH_BITS'(1);
      mode_d      = MODE_IDLE;
      case (ch_i)
        " ", CH_TAB, CH_CR: ;
        CH_LF:  line_d = (&line_q) ? line_q : line_q + LINE_BITS'(1);
        "a": begin mode_d = MODE_KEYWORD; kw_id_d = KW_AND;   kw_match_d = 3'd0; end
        "o": begin mode_d = MODE_KEYWORD; kw_id_d = KW_OR;    kw_match_d = 3'd0; end
        "t": begin mode_d = MODE_KEYWORD; kw_id_d = KW_TRUE;  kw_match_d = 3'd0; end
        "f": begin mode_d = MODE_KEYWORD; kw_id_d = KW_FALSE; kw_match_d = 3'd0; end
        "n":    mode_d = MODE_AFTER_N;
        "'", "\"": begin
          mode_d = MODE_STRING;
          dq_d   = (ch_i == "\"");
          esc_d  = 1'b0;
        end
        "+": begin e2_v = 1'b1; e2.kind = KIND_PLUS;   end
        "-": begin e2_v = 1'b1; e2.kind = KIND_MINUS;  end
        "*": begin e2_v = 1'b1; e2.kind = KIND_STAR;   end
        "/": begin e2_v = 1'b1; e2.kind = KIND_SLASH;  end
        "(": begin e2_v = 1'b1; e2.kind = KIND_LPAREN; end
        ")": begin e2_v = 1'b1; e2.kind = KIND_RPAREN; end
        ".": begin e2_v = 1'b1; e2.kind = KIND_DOT;    end
        "<":    mode_d = MODE_LT;
        ">":    mode_d = MODE_GT;
        "=":    mode_d = MODE_EQ;
        "!":    mode_d = MODE_BANG;
        CH_NUL: begin e2_v = 1'b1; e2.kind = KIND_EOF; end
        default: begin
          if (is_letter(ch_i)) begin
            mode_d = MODE_IDENT;
          end else if (is_digit(ch_i)) begin
            mode_d = MODE_NUMBER;
          end else begin
            e2_v   = 1'b1;
            e2.err = ERR_UNEXPECTED;
            e2.len = '0;
          end
        end
      endcase
    end

    // The first result is final unless the idle pass adds a second one.
    if (e1_v) begin
      e1.last = !e2_v;
    end
  end

  always_comb begin
    push_a = e1_v ? e1 : e2;
    push_b = e2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      kw_id_q     <= '0;
      kw_match_q  <= '0;
      dq_q        <= 1'b0;
      esc_q       <= 1'b0;
      tok_start_q <= '0;
      tok_len_q   <= '0;
      offset_q    <= '0;
      line_q      <= START_LINE_RESET;
    end else begin
      if (accept) begin
        mode_q      <= mode_d;
        kw_id_q     <= kw_id_d;
        kw_match_q  <= kw_match_d;
        dq_q        <= dq_d;
        esc_q       <= esc_d;
        tok_start_q <= tok_start_d;
        tok_len_q   <= tok_len_d;
        offset_q    <= offset_q + OFFSET_BITS'(1);
        line_q      <= line_d;
      end
      if (cfg_we_i) begin
        line_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (accept && (e1_v || e2_v)) begin
        wr_ptr_q <= wr_ptr_q + ((e1_v && e2_v) ? PTR_W'(2) : PTR_W'(1));
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      count_q <= count_q
               + (accept ? CNT_W'({1'b0, e1_v} + {1'b0, e2_v}) : CNT_W'(0))
               - (pop ? CNT_W'(1) : CNT_W'(0));
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (e1_v || e2_v)) begin
      queue_q[wr_ptr_q] <= push_a;
      if (e1_v && e2_v) begin
        queue_q[wr_ptr_q + PTR_W'(1)] <= push_b;
      end
    end
  end

  assign token_kind_o   = queue_q[rd_ptr_q].kind;
  assign error_kind_o   = queue_q[rd_ptr_q].err;
  assign start_offset_o = queue_q[rd_ptr_q].start;
  assign token_length_o = queue_q[rd_ptr_q].len;
  assign line_number_o  = queue_q[rd_ptr_q].line;
  assign last_o         = queue_q[rd_ptr_q].last;

endmodule

>>> hw/rtl/sll_checker.sv
// ----------------------------------------------------------------------------
// sll_checker
// Port-level checks on the token stream of the small language lexer.
// ----------------------------------------------------------------------------
module sll_checker #(
  parameter int unsigned LENGTH_BITS = sll_pkg::LENGTH_BITS_DEF,
  parameter int unsigned OFFSET_BITS = sll_pkg::OFFSET_BITS_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [4:0]                    token_kind_o,
  input logic [2:0]                    error_kind_o,
  input logic [OFFSET_BITS-1:0]        start_offset_o,
  input logic [LENGTH_BITS-1:0]        token_length_o,
  input logic [sll_pkg::LINE_BITS-1:0] line_number_o,
  input logic                          last_o
);
  import sll_pkg::*;

  // An error kind is reported exactly on error tokens.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((token_kind_o == KIND_ERROR) == (error_kind_o != ERR_NONE)))
    else $error("error kind does not match token kind");

  // Error tokens carry no length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && token_kind_o == KIND_ERROR) |-> (token_length_o == '0))
    else $error("error token with nonzero length");

  // End of source is one byte long and is always the final token of its byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && token_kind_o == KIND_EOF) |->
      (token_length_o == LENGTH_BITS'(1) && last_o))
    else $error("malformed end-of-source token");

  // A stalled result stays offered and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(token_kind_o) && $stable(error_kind_o) &&
       $stable(start_offset_o) && $stable(token_length_o) &&
       $stable(line_number_o) && $stable(last_o)))
    else $error("stalled result changed");

endmodule

bind small_language_lexer sll_checker #(
  .LENGTH_BITS(LENGTH_BITS),
  .OFFSET_BITS(OFFSET_BITS)
) u_sll_checker (.*);

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: small_language_lexer testbench
// Feeds source bytes through the valid/stall input channel and checks every
// token that leaves the output channel against a cycle-free model of the
// scanner kept in this file. A short scripted source covers keywords, the
// error kinds and end of source; random token streams and noise follow
// under several line-start settings.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sll_pkg::*;

  localparam logic [4:0] KIND_LE = KIND_LT + 5'd1;

  typedef struct packed {
    logic [4:0]  kind;
    logic [2:0]  err;
    logic [31:0] offset;
    logic [15:0] length;
    logic [23:0] line;
    logic        last;
  } token_t;

  typedef struct {
    logic [7:0]  ch;
    bit          typed;
    logic [4:0]  kind;
    logic [2:0]  err;
    logic [15:0] len;
  } step_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [23:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  ch = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  token_kind;
  logic [2:0]  error_kind;
  logic [31:0] start_offset;
  logic [15:0] token_length;
  logic [23:0] line_number;
  logic        last;

  small_language_lexer #(
    .LENGTH_BITS(16),
    .OFFSET_BITS(32)
  ) i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .ch_i          (ch),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .token_kind_o  (token_kind),
    .error_kind_o  (error_kind),
    .start_offset_o(start_offset),
    .token_length_o(token_length),
    .line_number_o (line_number),
    .last_o        (last)
  );

  always #10 clk = ~clk;

  // Scanner model state.
  scan_mode_e  mode_q;
  logic [2:0]  kw_id_q;
  logic [2:0]  kw_seen_q;
  bit          dq_q;
  bit          esc_q;
  logic [31:0] tok_start_q;
  logic [15:0] tok_len_q;
  logic [31:0] byte_off_q;
  logic [23:0] line_q;

  token_t     tokens_due[$];
  token_t     fresh[$];
  logic [7:0] pending[$];

  string kw_tails[6] = '{"nd", "r", "t", "l", "rue", "alse"};
  string kw_words[6] = '{"and", "or", "not", "nil", "true", "false"};
  string kw_starts = "antfo";
  string op_words[15] = '{"+", "-", "*", "/", "(", ")", ".", "<", "<=", ">", ">=",
                          "=", "==", "!=", "!"};
  logic [7:0] esc_chars[6] = '{"'", "\"", CH_BSL, "n", "r", "t"};
  logic [7:0] ws_chars[4] = '{" ", CH_TAB, CH_CR, CH_LF};

  // Scripted source: and, lone bang, unexpected byte, bad escape, newline
  // and end inside strings, <=, a keyword right before end of source.
  step_t script[25] = '{
    '{"+",    1'b1, KIND_PLUS,    ERR_NONE,       16'd1},
    '{"a",    1'b0, '0, '0, '0},
    '{"n",    1'b0, '0, '0, '0},
    '{"d",    1'b0, '0, '0, '0},
    '{" ",    1'b1, KIND_KW_BASE, ERR_NONE,       16'd3},
    '{"!",    1'b0, '0, '0, '0},
    '{"x",    1'b1, KIND_ERROR,   ERR_LONE_BANG,  16'd0},
    '{"$",    1'b1, KIND_ERROR,   ERR_UNEXPECTED, 16'd0},
    '{"'",    1'b0, '0, '0, '0},
    '{CH_BSL, 1'b0, '0, '0, '0},
    '{"q",    1'b1, KIND_ERROR,   ERR_BAD_ESCAPE, 16'd0},
    '{"\"",   1'b1, KIND_IDENT,   ERR_NONE,       16'd1},
    '{CH_LF,  1'b1, KIND_ERROR,   ERR_NL_IN_STR,  16'd0},
    '{"<",    1'b0, '0, '0, '0},
    '{"=",    1'b1, KIND_LE,      ERR_NONE,       16'd2},
    '{"9",    1'b0, '0, '0, '0},
    '{"9",    1'b0, '0, '0, '0},
    '{"t",    1'b1, KIND_NUMBER,  ERR_NONE,       16'd2},
    '{"r",    1'b0, '0, '0, '0},
    '{"u",    1'b0, '0, '0, '0},
    '{"e",    1'b0, '0, '0, '0},
    '{CH_NUL, 1'b1, KIND_EOF,     ERR_NONE,       16'd1},
    '{"'",    1'b0, '0, '0, '0},
    '{CH_NUL, 1'b1, KIND_EOF,     ERR_NONE,       16'd1},
    '{8'hFF,  1'b1, KIND_ERROR,   ERR_UNEXPECTED, 16'd0}
  };

  int  fails = 0;
  int  bytes_sent = 0;
  int  tokens_checked = 0;
  int  line_settings = 0;
  bit  calm = 1'b0;

  function automatic bit alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit decimal(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void reset_model();
    mode_q       = MODE_IDLE;
    kw_id_q      = '0;
    kw_seen_q    = '0;
    dq_q         = 1'b0;
    esc_q        = 1'b0;
    tok_start_q  = '0;
    tok_len_q    = '0;
    byte_off_q   = '0;
    line_q       = START_LINE_RESET;
  endfunction

  function automatic void grow_token();
    if (tok_len_q != 16'hFFFF) tok_len_q++;
  endfunction

  function automatic void add_token(logic [4:0] k, logic [2:0] e, logic [15:0] len);
    if (fresh.size() < 2) begin
      fresh.push_back('{kind: k, err: e, offset: tok_start_q, length: len,
                        line: line_q, last: 1'b0});
    end
  endfunction

  function automatic void enter_kw(logic [2:0] id);
    mode_q    = MODE_KEYWORD;
    kw_id_q   = id;
    kw_seen_q = '0;
  endfunction

  // Advances the model by one source byte and queues the tokens it makes.
  function automatic int lex_byte(logic [7:0] c);
    bit         done;
    logic [2:0] id;
    logic [7:0] quote;
    logic [4:0] single;
    fresh.delete();
    done = 1'b0;
    while (!done) begin
      case (mode_q)
        MODE_IDENT: begin
          if (alpha(c) || decimal(c)) begin
            grow_token();
            done = 1'b1;
          end else begin
            add_token(KIND_IDENT, ERR_NONE, tok_len_q);
            mode_q = MODE_IDLE;
          end
        end
        MODE_NUMBER: begin
          if (decimal(c)) begin
            grow_token();
            done = 1'b1;
          end else begin
            add_token(KIND_NUMBER, ERR_NONE, tok_len_q);
            mode_q = MODE_IDLE;
          end
        end
        MODE_AFTER_N: begin
          if (c == "i") begin
            grow_token();
            enter_kw(KW_NIL);
            done = 1'b1;
          end else if (c == "o") begin
            grow_token();
            enter_kw(KW_NOT);
            done = 1'b1;
          end else begin
            mode_q = MODE_IDENT;
          end
        end
        MODE_KEYWORD: begin
          id = (kw_id_q < 3'd6) ? kw_id_q : KW_AND;
          if (kw_seen_q < kw_tails[id].len() && c == kw_tails[id][kw_seen_q]) begin
            kw_seen_q++;
            grow_token();
            done = 1'b1;
          end else if (alpha(c) || decimal(c)) begin
            grow_token();
            mode_q = MODE_IDENT;
            done = 1'b1;
          end else begin
            if (kw_seen_q == kw_tails[id].len()) begin
              add_token(KIND_KW_BASE + {2'b00, id}, ERR_NONE, tok_len_q);
            end else begin
              add_token(KIND_IDENT, ERR_NONE, tok_len_q);
            end
            mode_q = MODE_IDLE;
          end
        end
        MODE_STRING: begin
          quote = dq_q ? "\"" : "'";
          if (esc_q) begin
            esc_q = 1'b0;
            if (c inside {"'", "\"", CH_BSL, "n", "r", "t"}) begin
              grow_token();
              done = 1'b1;
            end else begin
              add_token(KIND_ERROR, ERR_BAD_ESCAPE, 16'd0);
              mode_q = MODE_IDLE;
            end
          end else if (c == CH_LF) begin
            add_token(KIND_ERROR, ERR_NL_IN_STR, 16'd0);
            mode_q = MODE_IDLE;
          end else if (c == CH_NUL) begin
            add_token(KIND_ERROR, ERR_END_IN_STR, 16'd0);
            mode_q = MODE_IDLE;
          end else if (c == CH_BSL) begin
            esc_q = 1'b1;
            grow_token();
            done = 1'b1;
          end else if (c == quote) begin
            grow_token();
            add_token(dq_q ? KIND_DQ : KIND_SQ, ERR_NONE, tok_len_q);
            mode_q = MODE_IDLE;
            done = 1'b1;
          end else begin
            grow_token();
            done = 1'b1;
          end
        end
        MODE_LT, MODE_GT, MODE_EQ: begin
          single = (mode_q == MODE_LT) ? KIND_LT :
                   (mode_q == MODE_GT) ? KIND_GT : KIND_ASSIGN;
          if (c == "=") begin
            add_token(single + 5'd1, ERR_NONE, 16'd2);
            done = 1'b1;
          end else begin
            add_token(single, ERR_NONE, 16'd1);
          end
          mode_q = MODE_IDLE;
        end
        MODE_BANG: begin
          if (c == "=") begin
            add_token(KIND_NE, ERR_NONE, 16'd2);
            done = 1'b1;
          end else begin
            add_token(KIND_ERROR, ERR_LONE_BANG, 16'd0);
          end
          mode_q = MODE_IDLE;
        end
        default: begin
          // Between tokens every byte is consumed.
          tok_start_q = byte_off_q;
          tok_len_q   = 16'd1;
          mode_q      = MODE_IDLE;
          case (c)
            " ", CH_TAB, CH_CR: ;
            CH_LF: if (line_q != 24'hFFFFFF) line_q++;
            "a": enter_kw(KW_AND);
            "o": enter_kw(KW_OR);
            "t": enter_kw(KW_TRUE);
            "f": enter_kw(KW_FALSE);
            "n": mode_q = MODE_AFTER_N;
            "'", "\"": begin
              mode_q = MODE_STRING;
              dq_q   = (c == "\"");
              esc_q  = 1'b0;
            end
            "+": add_token(KIND_PLUS, ERR_NONE, 16'd1);
            "-": add_token(KIND_MINUS, ERR_NONE, 16'd1);
            "*": add_token(KIND_STAR, ERR_NONE, 16'd1);
            "/": add_token(KIND_SLASH, ERR_NONE, 16'd1);
            "(": add_token(KIND_LPAREN, ERR_NONE, 16'd1);
            ")": add_token(KIND_RPAREN, ERR_NONE, 16'd1);
            ".": add_token(KIND_DOT, ERR_NONE, 16'd1);
            "<": mode_q = MODE_LT;
            ">": mode_q = MODE_GT;
            "=": mode_q = MODE_EQ;
            "!": mode_q = MODE_BANG;
            CH_NUL: add_token(KIND_EOF, ERR_NONE, 16'd1);
            default: begin
              if (alpha(c)) mode_q = MODE_IDENT;
              else if (decimal(c)) mode_q = MODE_NUMBER;
              else add_token(KIND_ERROR, ERR_UNEXPECTED, 16'd0);
            end
          endcase
          done = 1'b1;
        end
      endcase
    end
    if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
    foreach (fresh[i]) tokens_due.push_back(fresh[i]);
    byte_off_q++;
    return fresh.size();
  endfunction

  // Mostly short pauses, now and then a long one, none in a calm stretch.
  function automatic int pause_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 3) == 0) return 8'("A" + $urandom_range(0, 25));
    return 8'("a" + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_alnum();
    if ($urandom_range(0, 3) == 0) return 8'("0" + $urandom_range(0, 9));
    return rand_letter();
  endfunction

  function automatic void push_word(string w);
    for (int i = 0; i < w.len(); i++) pending.push_back(w[i]);
  endfunction

  function automatic void push_string_lit();
    logic [7:0] quote;
    logic [7:0] c;
    int         r;
    quote = $urandom_range(0, 1) ? "\"" : "'";
    pending.push_back(quote);
    repeat ($urandom_range(0, 6)) begin
      if ($urandom_range(0, 4) == 0) begin
        pending.push_back(CH_BSL);
        pending.push_back(esc_chars[$urandom_range(0, 5)]);
      end else begin
        do c = 8'($urandom_range(32, 126)); while (c == quote || c == CH_BSL);
        pending.push_back(c);
      end
    end
    r = $urandom_range(0, 99);
    if (r < 85) begin
      pending.push_back(quote);
    end else if (r < 90) begin
      pending.push_back(CH_LF);
    end else if (r < 94) begin
      pending.push_back(CH_NUL);
    end else begin
      pending.push_back(CH_BSL);
      pending.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // Appends one random token, mostly well formed, sometimes raw noise.
  function automatic void queue_token();
    int r;
    r = $urandom_range(0, 99);
    if (r < 14) begin
      push_word(kw_words[$urandom_range(0, 5)]);
    end else if (r < 30) begin
      // Starting on a keyword's first letter exercises the prefix paths.
      if ($urandom_range(0, 1)) pending.push_back(kw_starts[$urandom_range(0, 4)]);
      else pending.push_back(rand_letter());
      repeat ($urandom_range(0, 7)) pending.push_back(rand_alnum());
    end else if (r < 42) begin
      repeat ($urandom_range(1, 6)) pending.push_back(8'("0" + $urandom_range(0, 9)));
    end else if (r < 56) begin
      push_string_lit();
    end else if (r < 72) begin
      push_word(op_words[$urandom_range(0, 14)]);
    end else if (r < 84) begin
      repeat ($urandom_range(1, 3)) pending.push_back(ws_chars[$urandom_range(0, 3)]);
    end else if (r < 88) begin
      pending.push_back(CH_NUL);
    end else begin
      repeat ($urandom_range(1, 3)) pending.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 9) < 6) pending.push_back(ws_chars[$urandom_range(0, 3)]);
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input int gap, output int n);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    ch       <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n = lex_byte(b);
    bytes_sent++;
  endtask

  // Waits until every queued token has come out, then lets the pipeline empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_start_line(input logic [23:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    line_q  = v;
    line_settings++;
  endtask

  task automatic run_phase(input int nbytes, input bit quiet);
    int sent;
    int n;
    calm = quiet;
    sent = 0;
    while (sent < nbytes) begin
      queue_token();
      while (pending.size() > 0) begin
        send_byte(pending.pop_front(), pause_len(), n);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    int          n;
    int          k;
    logic [23:0] v;
    reset_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      send_byte(script[i].ch, pause_len(), n);
      if (script[i].typed && n > 0) begin
        k = tokens_due.size() - 1;
        tokens_due[k].kind   = script[i].kind;
        tokens_due[k].err    = script[i].err;
        tokens_due[k].length = script[i].len;
      end
    end
    settle();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: v = 24'hFFFFFE;
        1: v = 24'hFFFFFF;
        2: v = 24'h000000;
        4: v = START_LINE_RESET;
        default: v = 24'($urandom);
      endcase
      write_start_line(v);
      run_phase(280, p == 2);
      settle();
    end
    repeat (8) @(posedge clk);

    $display("Lexed %0d source bytes under %0d line-start settings; %0d tokens compared.",
             bytes_sent, line_settings, tokens_checked);
    $display("Included: every error kind, line saturation, stalls on both channels.");
    if (fails == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : receiver
    int n;
    @(posedge rst_n);
    forever begin
      n = pause_len();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
    end
  end

  always @(posedge clk) begin : token_monitor
    token_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (tokens_due.size() == 0) begin
        $error("token with none pending: kind %0d at offset %0d", token_kind, start_offset);
        fails++;
      end else begin
        want = tokens_due.pop_front();
        check_field("token_kind", 64'(want.kind), 64'(token_kind));
        check_field("error_kind", 64'(want.err), 64'(error_kind));
        check_field("start_offset", 64'(want.offset), 64'(start_offset));
        check_field("token_length", 64'(want.length), 64'(token_length));
        check_field("line_number", 64'(want.line), 64'(line_number));
        check_field("last", 64'(want.last), 64'(last));
        tokens_checked++;
      end
    end
  end

  initial begin : watchdog
    #40_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
